/* hdl/assert_macros.svh */
// Assertion macros shared by the bit packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies the property in the next.
`define MBP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hdl/mbp_pkg.sv */
// Package: shared widths and the queued request type of the bit packer.
`default_nettype none

package mbp_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountW     = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PendW      = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic OpAppend = 1'b0;
  localparam logic OpFlush  = 1'b1;

  typedef struct packed {
    logic              flush;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
  } mbp_item_t;

endpackage

`default_nettype wire

/* hdl/mbp_channels.sv */
// Interfaces: request and byte channels of the bit packer.
`default_nettype none

interface mbp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [mbp_pkg::ValueW-1:0]     value;
  logic [mbp_pkg::CountW-1:0]     bit_count;

  modport source(output valid, op, value, bit_count, input ready);
  modport sink(input valid, op, value, bit_count, output ready);
endinterface

interface mbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [mbp_pkg::ByteW-1:0]      out_byte;
  logic                           last;

  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

/* hdl/mbp_front.sv */
// Front end: takes requests, decodes the op and clamps the bit count.
`default_nettype none

module mbp_front #(
  parameter int unsigned CountLimit = 32
) (
  mbp_in_if.sink                in_ch,
  input  wire logic             q_full,
  output logic                  push,
  output mbp_pkg::mbp_item_t    push_item
);

  localparam logic [mbp_pkg::CountW-1:0] LimitC = mbp_pkg::CountW'(CountLimit);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_item.flush = (in_ch.op == mbp_pkg::OpFlush);
    push_item.value = in_ch.value;
    if (push_item.flush) begin
      push_item.count = '0;
    end else if (in_ch.bit_count > LimitC) begin
      push_item.count = LimitC;
    end else begin
      push_item.count = in_ch.bit_count;
    end
  end

endmodule

`default_nettype wire

/* hdl/mbp_queue.sv */
// Short request queue between the front end and the packing back end.
`default_nettype none
`include "assert_macros.svh"

module mbp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  mbp_pkg::mbp_item_t    push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output mbp_pkg::mbp_item_t    head_item
);

  localparam int unsigned Depth = mbp_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(Depth);

  mbp_pkg::mbp_item_t mem_r [Depth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == DepthC);
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `MBP_ASSERT(a_q_no_underflow, pop |-> head_valid, "queue popped while empty")
  `MBP_ASSERT(a_q_cnt_bound, cnt_r <= DepthC, "queue count beyond depth")

endmodule

`default_nettype wire

/* hdl/mbp_back.sv */
// Back end: merges queued requests into the bit buffer and emits bytes.
`default_nettype none
`include "assert_macros.svh"

module mbp_back #(
  parameter int unsigned CountLimit = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  mbp_pkg::mbp_item_t    head_item,
  output logic                  pop,
  mbp_out_if.source             out_ch
);

  localparam int unsigned ByteW = mbp_pkg::ByteW;
  localparam int unsigned PendW = mbp_pkg::PendW;
  localparam int unsigned ValW  = mbp_pkg::ValueW;
  localparam int unsigned WordW = PendW + CountLimit;
  // wide enough for the fill count and for the two-byte compare bound
  localparam int unsigned NW    = $clog2(WordW + ByteW + 1);
  localparam logic [NW-1:0] ByteN  = NW'(ByteW);
  localparam logic [NW-1:0] TwoByteN = NW'(2 * ByteW);
  localparam logic [NW-1:0] WordN  = NW'(WordW);

  // word_r holds the unsent bits right aligned; only the low n_r are live.
  logic [WordW-1:0]  word_r, word_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic              out_valid_r;
  logic [ByteW-1:0]  out_byte_r;
  logic              out_last_r;

  logic              idle, slot_free, emit;
  logic [NW-1:0]     n_rem, n_eff;
  logic [WordW-1:0]  shifted;
  logic [ValW:0]     keep;
  logic [ValW-1:0]   val_m;
  logic [3:0]        pad;

  assign idle      = (n_r < ByteN);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = !idle && slot_free;
  assign n_rem     = n_r - ByteN;
  assign n_eff     = idle ? n_r : n_rem;
  // a new request may merge in the cycle its predecessor's last byte leaves
  assign pop       = head_valid && (idle || (emit && (n_r < TwoByteN)));
  assign shifted   = word_r >> n_rem;

  assign keep  = ~({(ValW + 1){1'b1}} << head_item.count);
  assign val_m = head_item.value & keep[ValW-1:0];
  assign pad   = 4'(ByteW) - {1'b0, n_eff[2:0]};

  always_comb begin
    word_nxt = word_r;
    n_nxt    = n_r;
    if (pop) begin
      if (head_item.flush) begin
        word_nxt = word_r << pad;
        n_nxt    = (n_eff == '0) ? '0 : ByteN;
      end else begin
        word_nxt = (WordW'(word_r[PendW-1:0]) << head_item.count) | WordW'(val_m);
        n_nxt    = n_eff + NW'(head_item.count);
      end
    end else if (emit) begin
      n_nxt = n_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r <= n_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (emit) begin
      out_byte_r <= shifted[ByteW-1:0];
      out_last_r <= (n_r < TwoByteN);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  `MBP_ASSERT(a_bk_fill_bound, n_r <= WordN, "bit buffer fill beyond word width")
  `MBP_ASSERT(a_bk_pop_merge, pop |-> (n_eff < ByteN), "merge with a full byte pending")
  `MBP_ASSERT_NEXT(a_bk_last_flag, emit && n_r < TwoByteN, out_valid_r && out_last_r, "no last")

endmodule

`default_nettype wire

/* hdl/msb_first_bit_packer_unit.sv */
// Top level of the MSB-first bit packer.
`default_nettype none

// MSB-first bit packer. Each request on in_ch either appends the low
// bit_count bits of value (op = 0, count clamped to min(MAX_BITS, 32)) or
// flushes (op = 1), padding pending bits with zeros to a whole byte. Every
// completed byte leaves on out_ch with the first appended bit in bit 7, and
// the final byte a request produces carries last = 1; requests that finish
// no byte produce nothing. Timing: the front end classifies a request in the
// cycle it is accepted and drops it into a two-entry queue; the back end takes
// a request from the queue and then sends one byte per cycle while out_ch is
// ready, through a registered output stage. An append completes zero to four
// bytes, and the next request merges in the same cycle as the previous
// request's last byte, so full 32-bit appends are limited by the
// one-byte-per-cycle output register. From an empty queue, an accepted
// request passes through the queue entry, the bit buffer and the output
// register before its first byte appears. The queue keeps in_ch ready while
// the back end is still draining bytes or out_ch is stalled, until it is full.
module msb_first_bit_packer_unit #(
  parameter int unsigned MAX_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mbp_in_if.sink      in_ch,
  mbp_out_if.source   out_ch
);

  // effective clamp: never more than the width of value
  localparam int unsigned CountLimit =
    (MAX_BITS < mbp_pkg::ValueW) ? MAX_BITS : mbp_pkg::ValueW;

  logic               q_full;
  logic               push;
  mbp_pkg::mbp_item_t push_item;
  logic               pop;
  logic               head_valid;
  mbp_pkg::mbp_item_t head_item;

  // front end: handshake and count clamp
  mbp_front #(
    .CountLimit(CountLimit)
  ) u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item)
  );

  // decoupling queue
  mbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  // back end: bit buffer and byte emission
  mbp_back #(
    .CountLimit(CountLimit)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_item (head_item),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* test/mbp_packer_checker.sv */
// Checker for the bit packer: predicts output bytes from accepted requests and compares them.
`default_nettype none

module mbp_packer_checker #(
  parameter int unsigned MAX_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        req_valid,
  input  wire logic                        req_ready,
  input  wire logic                        req_op,
  input  wire logic [mbp_pkg::ValueW-1:0]  req_value,
  input  wire logic [mbp_pkg::CountW-1:0]  req_count,
  input  wire logic                        byte_valid,
  input  wire logic                        byte_ready,
  input  wire logic [mbp_pkg::ByteW-1:0]   byte_data,
  input  wire logic                        byte_last,
  output int unsigned                      byte_errors,
  output int unsigned                      bytes_awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbp_pkg::*;

  localparam int unsigned CountLimit = (MAX_BITS < ValueW) ? MAX_BITS : ValueW;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } packed_byte_t;

  packed_byte_t     expected_bytes[$];
  logic [PendW-1:0] pend_bits;
  logic [2:0]       pend_cnt;
  int unsigned      errors;

  // Advance the pending-bit state by one request and queue the bytes it completes.
  function automatic void pack_request(input logic op, input logic [ValueW-1:0] value,
                                       input logic [CountW-1:0] count);
    logic [ByteW-1:0] acc;
    int unsigned      have;
    int unsigned      take;
    int unsigned      made;
    packed_byte_t     done[4];
    acc  = {1'b0, pend_bits};
    have = pend_cnt;
    made = 0;
    if (op == OpFlush) begin
      if (have != 0) begin
        done[0].data = acc << (ByteW - have);
        done[0].last = 1'b1;
        expected_bytes.push_back(done[0]);
      end
      pend_bits = '0;
      pend_cnt  = '0;
      return;
    end
    take = (count > CountLimit) ? CountLimit : count;
    for (int i = int'(take) - 1; i >= 0; i--) begin
      acc = {acc[ByteW-2:0], value[i]};
      have++;
      if (have == ByteW) begin
        done[made].data = acc;
        done[made].last = 1'b0;
        made++;
        acc  = '0;
        have = 0;
      end
    end
    for (int k = 0; k < int'(made); k++) begin
      if (k == int'(made) - 1) done[k].last = 1'b1;
      expected_bytes.push_back(done[k]);
    end
    pend_bits = acc[PendW-1:0];
    pend_cnt  = have[2:0];
  endfunction

  function automatic void log_error(input string what);
    errors++;
    if (errors <= ReportLimit) $display("%0t ns: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin : watch
    packed_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      pend_bits = '0;
      pend_cnt  = '0;
      errors    = 0;
    end else begin
      if (byte_valid && byte_ready) begin
        if (expected_bytes.size() == 0) begin
          log_error($sformatf("unexpected byte %02h last %0b", byte_data, byte_last));
        end else begin
          want = expected_bytes.pop_front();
          if (byte_data !== want.data || byte_last !== want.last)
            log_error($sformatf("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                want.data, want.last, byte_data, byte_last));
        end
      end
      if (req_valid && req_ready) pack_request(req_op, req_value, req_count);
    end
    byte_errors   <= errors;
    bytes_awaited <= expected_bytes.size();
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
// Top of the bit packer testbench: clock, reset, request stimulus, byte sink and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbp_pkg::*;

  localparam int unsigned PackMaxBits  = 32;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned DrainCycles  = 40;

  logic clk;
  logic rst_n;

  mbp_in_if  in_ch();
  mbp_out_if out_ch();

  int unsigned byte_errors;
  int unsigned bytes_awaited;

  // Percent of cycles the request side sits idle / the byte side refuses.
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  // Set by stimulus to ask the byte sink for one long hold-off.
  bit          hold_request;

  msb_first_bit_packer_unit #(
    .MAX_BITS(PackMaxBits)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  mbp_packer_checker #(
    .MAX_BITS(PackMaxBits)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_ch.valid),
    .req_ready    (in_ch.ready),
    .req_op       (in_ch.op),
    .req_value    (in_ch.value),
    .req_count    (in_ch.bit_count),
    .byte_valid   (out_ch.valid),
    .byte_ready   (out_ch.ready),
    .byte_data    (out_ch.out_byte),
    .byte_last    (out_ch.last),
    .byte_errors  (byte_errors),
    .bytes_awaited(bytes_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run (every request making four
  // bytes, each behind a long receiver stall, plus the hold-off).
  initial begin
    #1_000_000;
    $display("msb_first_bit_packer_unit regression: fail");
    $finish;
  end

  // Byte sink: random back-pressure, plus one long hold-off on request so
  // the internal queue fills and in_ch.ready drops.
  initial begin : byte_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Offer one request at the falling edge and wait for its handshake. valid
  // is left high on return so back-to-back requests never toggle it.
  task automatic send_request(input logic op, input logic [ValueW-1:0] value,
                              input logic [CountW-1:0] count);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.value     <= value;
    in_ch.bit_count <= count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random traffic: mostly appends of in-range counts, some oversize counts,
  // zero counts and flushes (fields of a flush are random noise).
  task automatic run_phase(input int unsigned items, input int unsigned idle_pct,
                           input int unsigned stall_pct, input bit with_hold);
    int unsigned      pick;
    logic             op;
    logic [CountW-1:0] count;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    if (with_hold) hold_request = 1'b1;
    repeat (items) begin
      pick  = $urandom_range(99, 0);
      op    = OpAppend;
      if (pick < 10)       op    = OpFlush;
      if (pick < 10)       count = CountW'($urandom_range(63, 0));
      else if (pick < 16)  count = CountW'($urandom_range(63, 33));   // clamps to the limit
      else if (pick < 21)  count = '0;
      else if (pick < 55)  count = CountW'($urandom_range(8, 1));
      else                 count = CountW'($urandom_range(32, 1));
      send_request(op, $urandom(), count);
    end
  endtask

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.op        = OpAppend;
    in_ch.value     = '0;
    in_ch.bit_count = '0;
    rst_n           = 1'b0;
    hold_request    = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases.
    send_request(OpAppend, 32'hDEADBEEF, 6'd0);   // zero count: nothing
    send_request(OpFlush,  32'h0,        6'd0);   // flush with nothing pending
    send_request(OpAppend, 32'hFFFFFFFF, 6'd32);  // four bytes of ones
    send_request(OpAppend, 32'h00000000, 6'd32);  // four bytes of zeros
    send_request(OpAppend, 32'hFFFFFFA5, 6'd8);   // upper value bits ignored
    send_request(OpAppend, 32'hFFFFFFF5, 6'd3);   // partial byte stays pending
    send_request(OpFlush,  32'hFFFFFFFF, 6'h3F);  // pad with zeros
    send_request(OpAppend, 32'h00000000, 6'd1);
    send_request(OpAppend, 32'h0000007F, 6'd7);   // completes a byte exactly
    send_request(OpAppend, 32'h12345678, 6'd63);  // max count field, clamped
    send_request(OpAppend, 32'h89ABCDEF, 6'd33);  // just over the limit
    send_request(OpAppend, 32'h00000005, 6'd5);
    send_request(OpAppend, 32'hCAFEF00D, 6'd31);  // straddles with bits pending
    send_request(OpAppend, 32'h00000003, 6'd2);
    send_request(OpAppend, 32'h00000000, 6'd7);
    send_request(OpFlush,  32'h00000000, 6'd0);
    send_request(OpFlush,  32'hFFFFFFFF, 6'h3F);  // second flush: nothing
    send_request(OpAppend, 32'hAAAAAAAB, 6'd1);   // single bit then flush
    send_request(OpFlush,  32'h0,        6'd0);
    send_request(OpAppend, 32'h0000007F, 6'd7);   // seven pending...
    send_request(OpAppend, 32'h80000001, 6'd32);  // ...plus 32: 39 bits
    send_request(OpFlush,  32'h0,        6'd0);

    // Random phases; the first also stalls the sink for a long stretch.
    run_phase(PhaseItems, 0,  0,  1'b1);
    run_phase(PhaseItems, 79, 0,  1'b0);
    run_phase(PhaseItems, 0,  79, 1'b0);
    run_phase(PhaseItems, 23, 23, 1'b0);
    in_ch.valid <= 1'b0;

    while (bytes_awaited != 0) @(posedge clk);
    // Give any stray extra bytes time to show up.
    repeat (DrainCycles) @(posedge clk);
    if (byte_errors == 0)
      $display("msb_first_bit_packer_unit regression: pass");
    else
      $display("msb_first_bit_packer_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
